[hw/rtl/nfpe_pkg.sv]
// Shared constants, types and codes of the NOR flash program/erase block.
`default_nettype none
package nfpe_pkg;

   // Array geometry.
   localparam int unsigned FLASH_WORDS = 32768;
   localparam int unsigned PAGE_BYTES  = 4096;
   localparam int unsigned PAGE_WORDS  = PAGE_BYTES / 4;
   localparam int unsigned WORD_AW     = $clog2(FLASH_WORDS);
   localparam int unsigned PAGE_AW     = $clog2(PAGE_WORDS);

   // Largest byte size the array can back.
   localparam logic [31:0] FLASH_CAP = 32'(FLASH_WORDS * 4);

   // Payload widths.
   localparam int unsigned ADDR_W  = 32;
   localparam int unsigned DATA_W  = 32;
   localparam int unsigned FBYTE_W = 18;

   // Configuration port.
   localparam int unsigned CSR_AW = 3;
   localparam int unsigned CSR_DW = 32;
   localparam logic        CSR_IDX_BASE = 1'b0;
   localparam logic        CSR_IDX_SIZE = 1'b1;

   localparam logic [FBYTE_W-1:0] FBYTE_RESET = 18'd131072;
   localparam logic [DATA_W-1:0]  RANGE_DATA  = 32'h0000_00FF;
   localparam logic [DATA_W-1:0]  ERASED_WORD = '1;

   typedef enum logic [1:0] {
      OP_READ    = 2'd0,
      OP_ERASE   = 2'd1,
      OP_PROGRAM = 2'd2,
      OP_ROW     = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_RANGE = 2'd1,
      STAT_ALIGN = 2'd2,
      STAT_UNSUP = 2'd3
   } status_type;

endpackage
`default_nettype wire

[hw/rtl/nfpe_req_if.sv]
// Request channel: operation, address and write data with valid/ready.
`default_nettype none
interface nfpe_req_if;
   import nfpe_pkg::*;

   logic                valid;
   logic                ready;
   op_type              operation;
   logic [ADDR_W-1:0]   address;
   logic [DATA_W-1:0]   write_data;

   modport source (output valid, output operation, output address, output write_data,
                   input ready);
   modport sink   (input valid, input operation, input address, input write_data,
                   output ready);
endinterface
`default_nettype wire

[hw/rtl/nfpe_rsp_if.sv]
// Response channel: read data and status with valid/ready.
`default_nettype none
interface nfpe_rsp_if;
   import nfpe_pkg::*;

   logic                valid;
   logic                ready;
   logic [DATA_W-1:0]   read_data;
   status_type          status;

   modport source (output valid, output read_data, output status, input ready);
   modport sink   (input valid, input read_data, input status, output ready);
endinterface
`default_nettype wire

[hw/rtl/nor_flash_program_erase.sv]
// Top level of the NOR flash array with page erase and word program.
//
// Usage:
// Requests arrive on the req channel; one transfer carries an operation, a full
// physical byte address and a data word. Each request yields exactly one
// transfer on the rsp channel with the read data and a status code. The block
// handles one request at a time: req.ready is high only while it is idle.
// Out-of-range, misaligned and row program requests pass from ST_SUB and
// ST_CHECK straight to ST_RESP; a read adds ST_RDATA and a word program adds
// ST_PROG before ST_RESP, and a page erase adds ST_ERASE, which walks the page one
// word per cycle through the single memory write port. A new request is taken
// the cycle after the response transfer. Offset subtraction, range compare,
// memory read and write each take a sequencer state of their own in the shared datapath.
// After reset the block sweeps the whole array to all ones, one word per cycle
// (FLASH_WORDS = 32768 words); req.ready stays low during the sweep, while
// configuration writes are taken as usual. Reset also restores base_address to
// 0 and flash_bytes to 131072. If the receiver holds rsp.ready low, the
// response stays registered and stable and no new request is taken.
`default_nettype none
module nor_flash_program_erase (
   input  wire                         clock,
   input  wire                         reset,
   nfpe_req_if.sink                    req,
   nfpe_rsp_if.source                  rsp,
   input  wire                         csr_psel,
   input  wire                         csr_penable,
   input  wire                         csr_pwrite,
   input  wire [nfpe_pkg::CSR_AW-1:0]  csr_paddr,
   input  wire [nfpe_pkg::CSR_DW-1:0]  csr_pwdata,
   output logic [nfpe_pkg::CSR_DW-1:0] csr_prdata,
   output logic                        csr_pready
);
   import nfpe_pkg::*;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SUB,
      ST_CHECK,
      ST_RDATA,
      ST_PROG,
      ST_ERASE,
      ST_RESP
   } state_type;

   // Sequencer state and the request held while it is processed.
   state_type            state_ff,  state_in;
   logic [WORD_AW-1:0]   cnt_ff,    cnt_in;
   op_type               op_ff,     op_in;
   logic [ADDR_W-1:0]    addr_ff,   addr_in;
   logic [DATA_W-1:0]    wdata_ff,  wdata_in;
   logic [ADDR_W-1:0]    offset_ff, offset_in;
   logic [31:0]          size_ff,   size_in;
   logic [DATA_W-1:0]    rdata_ff,  rdata_in;
   status_type           status_ff, status_in;

   // Configuration registers.
   logic [ADDR_W-1:0]    base_ff;
   logic [FBYTE_W-1:0]   fbytes_ff;

   // Flash array and its ports.
   logic [DATA_W-1:0]    mem [FLASH_WORDS];
   logic [DATA_W-1:0]    mem_rdata_ff;
   logic [WORD_AW-1:0]   mem_raddr;
   logic [WORD_AW-1:0]   mem_waddr;
   logic [DATA_W-1:0]    mem_wdata;
   logic                 mem_we;
   logic                 csr_wr;

   // The word index of the current offset; upper offset bits are zero once
   // the range check has passed.
   assign mem_raddr = offset_ff[WORD_AW+1:2];

   // Configuration port. Only bit 2 of the address selects a register.
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      unique case (csr_paddr[2])
         CSR_IDX_BASE: csr_prdata = base_ff;
         CSR_IDX_SIZE: csr_prdata = {{(CSR_DW-FBYTE_W){1'b0}}, fbytes_ff};
         default:      csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff   <= '0;
         fbytes_ff <= FBYTE_RESET;
      end else if (csr_wr) begin
         unique case (csr_paddr[2])
            CSR_IDX_BASE: base_ff   <= csr_pwdata;
            CSR_IDX_SIZE: fbytes_ff <= csr_pwdata[FBYTE_W-1:0];
            default:      base_ff   <= base_ff;
         endcase
      end
   end

   // Handshake outputs follow the sequencer state directly.
   assign req.ready     = (state_ff == ST_IDLE);
   assign rsp.valid     = (state_ff == ST_RESP);
   assign rsp.read_data = rdata_ff;
   assign rsp.status    = status_ff;

   // Memory write port: the reset sweep and page erase write all ones at the
   // walking counter, and a word program writes back the ANDed word.
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = cnt_ff;
      mem_wdata = ERASED_WORD;
      unique case (state_ff)
         ST_CLEAR, ST_ERASE: begin
            mem_we = 1'b1;
         end
         ST_PROG: begin
            mem_we    = 1'b1;
            mem_waddr = mem_raddr;
            mem_wdata = mem_rdata_ff & wdata_ff;
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      mem_rdata_ff <= mem[mem_raddr];
   end

   // Sequencer next-state logic.
   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      op_in     = op_ff;
      addr_in   = addr_ff;
      wdata_in  = wdata_ff;
      offset_in = offset_ff;
      size_in   = size_ff;
      rdata_in  = rdata_ff;
      status_in = status_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == WORD_AW'(FLASH_WORDS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req.valid) begin
               op_in    = req.operation;
               addr_in  = req.address;
               wdata_in = req.write_data;
               state_in = ST_SUB;
            end
         end
         ST_SUB: begin
            // Offset wraps modulo 2^32; the size in effect is capped by the array.
            offset_in = addr_ff - base_ff;
            size_in   = (32'(fbytes_ff) < FLASH_CAP) ? 32'(fbytes_ff) : FLASH_CAP;
            state_in  = ST_CHECK;
         end
         ST_CHECK: begin
            rdata_in  = '0;
            status_in = STAT_OK;
            if (offset_ff >= size_ff) begin
               rdata_in  = RANGE_DATA;
               status_in = STAT_RANGE;
               state_in  = ST_RESP;
            end else begin
               unique case (op_ff)
                  OP_READ: begin
                     state_in = ST_RDATA;
                  end
                  OP_ERASE: begin
                     if (offset_ff[PAGE_AW+1:0] != '0) begin
                        status_in = STAT_ALIGN;
                        state_in  = ST_RESP;
                     end else begin
                        cnt_in   = {offset_ff[WORD_AW+1:PAGE_AW+2], {PAGE_AW{1'b0}}};
                        state_in = ST_ERASE;
                     end
                  end
                  OP_PROGRAM: begin
                     if (offset_ff[1:0] != 2'b00) begin
                        status_in = STAT_ALIGN;
                        state_in  = ST_RESP;
                     end else begin
                        state_in = ST_PROG;
                     end
                  end
                  OP_ROW: begin
                     status_in = STAT_UNSUP;
                     state_in  = ST_RESP;
                  end
                  default: begin
                     state_in = ST_RESP;
                  end
               endcase
            end
         end
         ST_RDATA: begin
            rdata_in = mem_rdata_ff;
            state_in = ST_RESP;
         end
         ST_PROG: begin
            state_in = ST_RESP;
         end
         ST_ERASE: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff[PAGE_AW-1:0] == {PAGE_AW{1'b1}}) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (rsp.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
      op_ff     <= op_in;
      addr_ff   <= addr_in;
      wdata_ff  <= wdata_in;
      offset_ff <= offset_in;
      size_ff   <= size_in;
      rdata_ff  <= rdata_in;
      status_ff <= status_in;
   end

endmodule
`default_nettype wire

[hw/rtl/nfpe_chk.sv]
// Port-level checks of the NOR flash block, bound to its top level.
`default_nettype none
module nfpe_chk (
   input wire                          clock,
   input wire                          reset,
   input wire                          req_valid,
   input wire                          req_ready,
   input wire                          rsp_valid,
   input wire                          rsp_ready,
   input wire [nfpe_pkg::DATA_W-1:0]   rsp_read_data,
   input wire [1:0]                    rsp_status
);
   import nfpe_pkg::*;

   // A stalled response keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_data)
                                  && $stable(rsp_status))
      else $error("stalled response changed");

   // No request is taken while a response is pending.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request taken while response pending");

   // An accepted request is never answered in the following cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready && !rsp_valid)
      else $error("response too early after request");

   // An out-of-range response carries 0xFF as its data.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STAT_RANGE) |-> rsp_read_data == RANGE_DATA)
      else $error("out-of-range data wrong");

   assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_ready)
      else $error("block active right after reset");

endmodule

bind nor_flash_program_erase nfpe_chk u_nfpe_chk (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req.valid),
   .req_ready     (req.ready),
   .rsp_valid     (rsp.valid),
   .rsp_ready     (rsp.ready),
   .rsp_read_data (rsp.read_data),
   .rsp_status    (rsp.status)
);
`default_nettype wire
